>>> hdl/xrrg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xrrg_pkg: shared definitions of the range random generator
// Field widths, operation codes, SplitMix64 constants and unit status type.
// ----------------------------------------------------------------------------
package xrrg_pkg;

  localparam int WORD_W   = 64;
  localparam int VAL_W    = 32;
  localparam int SPAN_W   = 33;
  localparam int FUNC_W   = 2;
  localparam int COUNT_W  = 7;

  localparam int DEFAULT_MAX_DRAWS = 64;

  localparam logic [FUNC_W-1:0] FN_RESEED = 2'd0;
  localparam logic [FUNC_W-1:0] FN_RANGE  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_RAW    = 2'd2;

  localparam logic [WORD_W-1:0] SM_GAMMA = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [WORD_W-1:0] SM_MUL1  = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [WORD_W-1:0] SM_MUL2  = 64'h94d0_49bb_1331_11eb;

  localparam int SHL_T   = 17;
  localparam int ROT_W3  = 45;
  localparam int ROT_OUT = 7;

  localparam logic [WORD_W-1:0] OUT_MUL_A = 64'd5;
  localparam logic [WORD_W-1:0] OUT_MUL_B = 64'd9;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage
`default_nettype wire

>>> hdl/xrrg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xrrg_if: request and result channels
// Valid/ready channels carrying one request and one result item.
// ----------------------------------------------------------------------------
interface xrrg_in_if import xrrg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [VAL_W-1:0]  low_bound;
  logic signed [VAL_W-1:0]  high_bound;
  logic [COUNT_W-1:0]       draw_count;
  logic                     sum_mode;

  modport source (output valid, func, low_bound, high_bound, draw_count, sum_mode,
                  input ready);
  modport sink   (input valid, func, low_bound, high_bound, draw_count, sum_mode,
                  output ready);
endinterface

interface xrrg_out_if import xrrg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  range_value;
  logic [WORD_W-1:0]        raw_word;
  logic                     last;

  modport source (output valid, range_value, raw_word, last, input ready);
  modport sink   (input valid, range_value, raw_word, last, output ready);
endinterface
`default_nettype wire

>>> hdl/xoshiro_range_random_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xoshiro_range_random_generator: xoshiro256** range random generator
// Raw 64-bit draws, range draws and range sums, seeded by SplitMix64.
// ----------------------------------------------------------------------------
// One request is worked on at a time. A raw draw runs the output scrambling:
// it multiplies by 5 and by 9 in the bit-serial multiplier, which handles one
// multiplier bit per cycle. Each range value then also passes through the
// bit-serial remainder unit; a sum request of n draws gives its one result
// after the last of its draws. A reseed makes four SplitMix64 words, each
// needing two serial multiplies. The same seeding pass runs after reset, with
// seed 0, and no request is accepted until it finishes. Writing cfg_wdata
// only stores the seed; it takes effect on the next reseed request. A finished
// result waits in the output register while the next request is accepted.
// ----------------------------------------------------------------------------
module xoshiro_range_random_generator import xrrg_pkg::*; #(
  parameter int MAX_DRAWS = DEFAULT_MAX_DRAWS
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  xrrg_in_if.sink           in_req,
  xrrg_out_if.source        out_res,
  input  wire logic         cfg_we,
  input  wire logic [VAL_W-1:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_DRAWS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SM_ADD, S_SM_M1, S_SM_M2, S_DRAW, S_R5, S_R9, S_MOD, S_PUT
  } state_t;

  state_t            state_r;
  logic [VAL_W-1:0]  seed_r;
  logic [WORD_W-1:0] w_r [4];
  logic [WORD_W-1:0] acc_r;
  logic [1:0]        k_r;
  logic              rsp_r;
  logic              raw_r;
  logic              summ_r;
  logic [VAL_W-1:0]  lo_r;
  logic [SPAN_W-1:0] span_r;
  logic [CW-1:0]     total_r;
  logic [CW-1:0]     cnt_r;
  logic [VAL_W-1:0]  sum_r;
  logic [VAL_W-1:0]  res_range_r;
  logic [WORD_W-1:0] res_raw_r;
  logic              res_last_r;
  logic              out_v_r;
  logic [VAL_W-1:0]  out_range_r;
  logic [WORD_W-1:0] out_raw_r;
  logic              out_last_r;

  logic              mul_start;
  logic [WORD_W-1:0] mul_a;
  logic [WORD_W-1:0] mul_b;
  unit_stat_t        mul_st;
  logic [WORD_W-1:0] mul_p;
  logic              mod_start;
  unit_stat_t        mod_st;
  logic [SPAN_W-1:0] mod_rem;

  logic [WORD_W-1:0] sm_z;
  logic [WORD_W-1:0] xs_t;
  logic [WORD_W-1:0] xs_n0, xs_n1, xs_n2, xs_n3;
  logic [VAL_W-1:0]  lo_sel, hi_sel;
  logic [SPAN_W-1:0] span_nxt;
  logic [VAL_W-1:0]  v_nxt;
  logic [VAL_W-1:0]  sum_nxt;
  logic              fin;
  logic              out_free;
  logic              in_acc;

  assign in_acc   = in_req.valid && in_req.ready;
  assign out_free = !out_v_r || out_res.ready;
  assign sm_z     = acc_r + SM_GAMMA;

  // xoshiro256** state advance
  assign xs_t  = w_r[1] << SHL_T;
  assign xs_n2 = w_r[2] ^ w_r[0];
  assign xs_n3 = w_r[3] ^ w_r[1];
  assign xs_n1 = w_r[1] ^ xs_n2;
  assign xs_n0 = w_r[0] ^ xs_n3;

  assign lo_sel   = (in_req.high_bound < in_req.low_bound) ? in_req.high_bound
                                                           : in_req.low_bound;
  assign hi_sel   = (in_req.high_bound < in_req.low_bound) ? in_req.low_bound
                                                           : in_req.high_bound;
  assign span_nxt = {hi_sel[VAL_W-1], hi_sel} - {lo_sel[VAL_W-1], lo_sel} + SPAN_W'(1);

  assign v_nxt   = mod_rem[VAL_W-1:0] + lo_r;
  assign sum_nxt = sum_r + v_nxt;
  assign fin     = (cnt_r + CW'(1)) == total_r;

  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    mod_start = 1'b0;
    case (state_r)
      S_SM_ADD: begin
        mul_start = 1'b1;
        mul_a     = sm_z ^ (sm_z >> 30);
        mul_b     = SM_MUL1;
      end
      S_SM_M1: begin
        mul_start = mul_st.done;
        mul_a     = mul_p ^ (mul_p >> 27);
        mul_b     = SM_MUL2;
      end
      S_DRAW: begin
        mul_start = 1'b1;
        mul_a     = w_r[1];
        mul_b     = OUT_MUL_A;
      end
      S_R5: begin
        mul_start = mul_st.done;
        mul_a     = {mul_p[WORD_W-1-ROT_OUT:0], mul_p[WORD_W-1:WORD_W-ROT_OUT]};
        mul_b     = OUT_MUL_B;
      end
      S_R9: begin
        mod_start = mul_st.done && !raw_r;
      end
      default: begin
      end
    endcase
  end

  xrrg_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (mul_a),
    .mplier (mul_b),
    .stat   (mul_st),
    .prod   (mul_p)
  );

  xrrg_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mul_p),
    .divisor  (span_r),
    .stat     (mod_st),
    .rem      (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SM_ADD;
      seed_r  <= '0;
      acc_r   <= '0;
      k_r     <= '0;
      rsp_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        seed_r <= cfg_wdata;
      end
      if ((state_r == S_PUT) && out_free) begin
        out_v_r <= 1'b1;
      end else if (out_res.ready) begin
        out_v_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (in_req.func)
              FN_RESEED: begin
                acc_r   <= {{(WORD_W-VAL_W){1'b0}}, seed_r};
                k_r     <= '0;
                rsp_r   <= 1'b1;
                state_r <= S_SM_ADD;
              end
              FN_RANGE: begin
                lo_r    <= lo_sel;
                span_r  <= span_nxt;
                total_r <= (in_req.draw_count > COUNT_W'(MAX_DRAWS)) ? CW'(MAX_DRAWS)
                                                                    : in_req.draw_count[CW-1:0];
                summ_r  <= in_req.sum_mode;
                raw_r   <= 1'b0;
                cnt_r   <= '0;
                sum_r   <= '0;
                if (in_req.draw_count != '0) begin
                  state_r <= S_DRAW;
                end
              end
              FN_RAW: begin
                raw_r   <= 1'b1;
                state_r <= S_DRAW;
              end
              default: begin
              end
            endcase
          end
        end
        S_SM_ADD: begin
          acc_r   <= sm_z;
          state_r <= S_SM_M1;
        end
        S_SM_M1: begin
          if (mul_st.done) begin
            state_r <= S_SM_M2;
          end
        end
        S_SM_M2: begin
          if (mul_st.done) begin
            w_r[k_r] <= mul_p ^ (mul_p >> 31);
            k_r      <= k_r + 2'd1;
            if (k_r == 2'd3) begin
              res_range_r <= '0;
              res_raw_r   <= '0;
              res_last_r  <= 1'b1;
              state_r     <= rsp_r ? S_PUT : S_IDLE;
            end else begin
              state_r <= S_SM_ADD;
            end
          end
        end
        S_DRAW: begin
          w_r[0]  <= xs_n0;
          w_r[1]  <= xs_n1;
          w_r[2]  <= xs_n2 ^ xs_t;
          w_r[3]  <= {xs_n3[WORD_W-1-ROT_W3:0], xs_n3[WORD_W-1:WORD_W-ROT_W3]};
          state_r <= S_R5;
        end
        S_R5: begin
          if (mul_st.done) begin
            state_r <= S_R9;
          end
        end
        S_R9: begin
          if (mul_st.done) begin
            if (raw_r) begin
              res_range_r <= '0;
              res_raw_r   <= mul_p;
              res_last_r  <= 1'b1;
              state_r     <= S_PUT;
            end else begin
              state_r <= S_MOD;
            end
          end
        end
        S_MOD: begin
          if (mod_st.done) begin
            sum_r     <= sum_nxt;
            cnt_r     <= cnt_r + CW'(1);
            res_raw_r <= '0;
            if (!summ_r) begin
              res_range_r <= v_nxt;
              res_last_r  <= fin;
              state_r     <= S_PUT;
            end else if (fin) begin
              res_range_r <= sum_nxt;
              res_last_r  <= 1'b1;
              state_r     <= S_PUT;
            end else begin
              state_r <= S_DRAW;
            end
          end
        end
        S_PUT: begin
          if (out_free) begin
            out_range_r <= res_range_r;
            out_raw_r   <= res_raw_r;
            out_last_r  <= res_last_r;
            state_r     <= res_last_r ? S_IDLE : S_DRAW;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_req.ready        = (state_r == S_IDLE);
  assign out_res.valid       = out_v_r;
  assign out_res.range_value = out_range_r;
  assign out_res.raw_word    = out_raw_r;
  assign out_res.last        = out_last_r;

endmodule
`default_nettype wire

>>> hdl/xrrg_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xrrg_mul: bit-serial multiplier
// Low 64 bits of a product, one multiplier bit per cycle, stops when the
// remaining multiplier bits are all zero.
// ----------------------------------------------------------------------------
module xrrg_mul import xrrg_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] mcand,
  input  wire logic [WORD_W-1:0] mplier,
  output unit_stat_t             stat,
  output logic      [WORD_W-1:0] prod
);

  logic              busy_r;
  logic [WORD_W-1:0] a_r;
  logic [WORD_W-1:0] b_r;
  logic [WORD_W-1:0] acc_r;
  logic [WORD_W-1:0] acc_nxt;

  assign acc_nxt = b_r[0] ? (acc_r + a_r) : acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      a_r    <= mcand;
      b_r    <= mplier;
      acc_r  <= '0;
    end else if (busy_r) begin
      if (b_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        acc_r <= acc_nxt;
        a_r   <= {a_r[WORD_W-2:0], 1'b0};
        b_r   <= {1'b0, b_r[WORD_W-1:1]};
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = busy_r && (b_r == '0);
  assign prod      = acc_r;

endmodule
`default_nettype wire

>>> hdl/xrrg_mod.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xrrg_mod: bit-serial remainder unit
// Restoring division of a 64-bit word by a 33-bit span, one dividend bit
// per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module xrrg_mod import xrrg_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] dividend,
  input  wire logic [SPAN_W-1:0] divisor,
  output unit_stat_t             stat,
  output logic      [SPAN_W-1:0] rem
);

  localparam int CNT_W = $clog2(WORD_W + 1);

  logic              busy_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [WORD_W-1:0] n_r;
  logic [SPAN_W-1:0] d_r;
  logic [SPAN_W-1:0] rem_r;
  logic [SPAN_W:0]   trial;
  logic [SPAN_W:0]   diff;
  logic [SPAN_W-1:0] rem_nxt;

  assign trial   = {rem_r, n_r[WORD_W-1]};
  assign diff    = trial - {1'b0, d_r};
  assign rem_nxt = (trial >= {1'b0, d_r}) ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      n_r    <= dividend;
      d_r    <= divisor;
      rem_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r == CNT_W'(WORD_W)) begin
        busy_r <= 1'b0;
      end else begin
        rem_r <= rem_nxt;
        n_r   <= {n_r[WORD_W-2:0], 1'b0};
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = busy_r && (cnt_r == CNT_W'(WORD_W));
  assign rem       = rem_r;

endmodule
`default_nettype wire

>>> hdl/xrrg_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xrrg_checker: port-level checks of the range random generator
// Result channel rules, field consistency, reset readiness; bound to top level.
// ----------------------------------------------------------------------------
module xrrg_checker import xrrg_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [VAL_W-1:0]  out_range_value,
  input wire logic [WORD_W-1:0] out_raw_word,
  input wire logic              out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_range_value) && $stable(out_raw_word)
                                && $stable(out_last))
    else $error("stalled result changed");

  a_field_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_raw_word == '0) || (out_range_value == '0))
    else $error("raw and range fields both set");

  a_raw_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_raw_word != '0) |-> out_last)
    else $error("raw result without last");

  a_seed_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_ready)
    else $error("request taken during seeding after reset");

endmodule

bind xoshiro_range_random_generator xrrg_checker u_xrrg_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_req.ready),
  .out_valid       (out_res.valid),
  .out_ready       (out_res.ready),
  .out_range_value (out_res.range_value),
  .out_raw_word    (out_res.raw_word),
  .out_last        (out_res.last)
);
`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: xoshiro range random generator check
// Sends corner-case and random requests with random stalls on both channels.
// Every result is predicted from a separate xoshiro256** / SplitMix64 model.
// Each returned result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import xrrg_pkg::*;

  localparam logic [FUNC_W-1:0]       FN_UNUSED        = 2'd3;
  localparam logic signed [VAL_W-1:0] INT_MIN          = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] INT_MAX          = 32'sh7fff_ffff;
  localparam int                      MAX_DRAWS        = DEFAULT_MAX_DRAWS;
  localparam int                      SETTLE_CYCLES    = 1000;
  localparam int                      RANDOM_PER_PHASE = 96;

  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic signed [VAL_W-1:0] low_bound;
    logic signed [VAL_W-1:0] high_bound;
    logic [COUNT_W-1:0]      draw_count;
    logic                    sum_mode;
  } draw_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] range_value;
    logic [WORD_W-1:0]       raw_word;
    logic                    last;
  } draw_res_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [VAL_W-1:0] cfg_wdata;

  xrrg_in_if  in_ch ();
  xrrg_out_if out_ch ();

  xoshiro_range_random_generator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_ch.sink),
    .out_res   (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  draw_req_t         request_queue[$];
  draw_res_t         awaited_results[$];
  logic [WORD_W-1:0] gen_state[4];
  logic [VAL_W-1:0]  seed_reg;
  int                sent_cnt     = 0;
  int                accepted_cnt = 0;
  int                error_cnt    = 0;
  int                in_idle_pct  = 0;
  int                out_idle_pct = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int k);
    return (v << k) | (v >> (WORD_W - k));
  endfunction

  function automatic void splitmix_seed(input logic [VAL_W-1:0] s);
    logic [WORD_W-1:0] acc;
    logic [WORD_W-1:0] z;
    acc = {{(WORD_W-VAL_W){1'b0}}, s};
    for (int i = 0; i < 4; i++) begin
      acc = acc + SM_GAMMA;
      z = (acc ^ (acc >> 30)) * SM_MUL1;
      z = (z ^ (z >> 27)) * SM_MUL2;
      gen_state[i] = z ^ (z >> 31);
    end
  endfunction

  function automatic logic [WORD_W-1:0] xoshiro_next();
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] t;
    word = rotl(gen_state[1] * OUT_MUL_A, ROT_OUT) * OUT_MUL_B;
    t = gen_state[1] << SHL_T;
    gen_state[2] = gen_state[2] ^ gen_state[0];
    gen_state[3] = gen_state[3] ^ gen_state[1];
    gen_state[1] = gen_state[1] ^ gen_state[2];
    gen_state[0] = gen_state[0] ^ gen_state[3];
    gen_state[2] = gen_state[2] ^ t;
    gen_state[3] = rotl(gen_state[3], ROT_W3);
    return word;
  endfunction

  function automatic void await_result(input logic [VAL_W-1:0] rv,
                                       input logic [WORD_W-1:0] raw, input logic is_last);
    draw_res_t res;
    res.range_value = rv;
    res.raw_word    = raw;
    res.last        = is_last;
    awaited_results = {awaited_results, res};
  endfunction

  function automatic void compute_draws(input draw_req_t r);
    logic signed [SPAN_W-1:0] lo;
    logic signed [SPAN_W-1:0] hi;
    logic signed [SPAN_W-1:0] tmp;
    logic [SPAN_W-1:0]        span;
    logic [WORD_W-1:0]        rem;
    logic [VAL_W-1:0]         value;
    logic [VAL_W-1:0]         sum;
    int                       cnt;
    case (r.func)
      FN_RESEED: begin
        splitmix_seed(seed_reg);
        await_result('0, '0, 1'b1);
      end
      FN_RAW: begin
        await_result('0, xoshiro_next(), 1'b1);
      end
      FN_RANGE: begin
        cnt = (r.draw_count > MAX_DRAWS) ? MAX_DRAWS : int'(r.draw_count);
        lo = $signed(r.low_bound);
        hi = $signed(r.high_bound);
        if (hi < lo) begin
          tmp = lo;
          lo  = hi;
          hi  = tmp;
        end
        span = hi - lo + 1;
        sum  = '0;
        for (int i = 0; i < cnt; i++) begin
          rem   = xoshiro_next() % {{(WORD_W-SPAN_W){1'b0}}, span};
          value = rem[VAL_W-1:0] + lo[VAL_W-1:0];
          sum   = sum + value;
          if (!r.sum_mode) await_result(value, '0, i == cnt - 1);
        end
        if (r.sum_mode && cnt > 0) await_result(sum, '0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  // check results before predicting the request taken at the same edge
  always @(posedge clk) begin : check_results
    draw_res_t want;
    draw_req_t taken;
    if (!rst_n) begin
      seed_reg = '0;
      splitmix_seed('0);
      awaited_results.delete();
    end else begin
      if (cfg_we) seed_reg = cfg_wdata;
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result: range_value %0d raw_word %h last %b",
                 out_ch.range_value, out_ch.raw_word, out_ch.last);
          error_cnt++;
        end else begin
          want = awaited_results.pop_front();
          if (out_ch.range_value !== want.range_value) begin
            $error("range_value: expected %0d, got %0d",
                   $signed(want.range_value), out_ch.range_value);
            error_cnt++;
          end
          if (out_ch.raw_word !== want.raw_word) begin
            $error("raw_word: expected %h, got %h", want.raw_word, out_ch.raw_word);
            error_cnt++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_ch.last);
            error_cnt++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        accepted_cnt++;
        taken.func       = in_ch.func;
        taken.low_bound  = in_ch.low_bound;
        taken.high_bound = in_ch.high_bound;
        taken.draw_count = in_ch.draw_count;
        taken.sum_mode   = in_ch.sum_mode;
        compute_draws(taken);
      end
    end
  end

  // hold a request until taken, then advance or idle
  always @(negedge clk) begin : drive_requests
    draw_req_t next_req;
    if (!in_ch.valid || accepted_cnt == sent_cnt) begin
      if (request_queue.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
        next_req = request_queue.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.func       <= next_req.func;
        in_ch.low_bound  <= next_req.low_bound;
        in_ch.high_bound <= next_req.high_bound;
        in_ch.draw_count <= next_req.draw_count;
        in_ch.sum_mode   <= next_req.sum_mode;
        sent_cnt++;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  task automatic add_request(input logic [FUNC_W-1:0] func, input logic signed [VAL_W-1:0] lo,
                             input logic signed [VAL_W-1:0] hi,
                             input logic [COUNT_W-1:0] cnt, input logic sm);
    draw_req_t r;
    r.func       = func;
    r.low_bound  = lo;
    r.high_bound = hi;
    r.draw_count = cnt;
    r.sum_mode   = sm;
    request_queue = {request_queue, r};
  endtask

  function automatic logic signed [VAL_W-1:0] pick_bound();
    case ($urandom_range(5))
      0:       return INT_MIN;
      1:       return INT_MAX;
      2, 3:    return int'($urandom_range(200)) - 100;
      default: return $urandom();
    endcase
  endfunction

  // keep most counts small; the block works through the draws one at a time
  function automatic logic [COUNT_W-1:0] pick_count();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return COUNT_W'($urandom_range(4, 1));
    if (pick < 90) return COUNT_W'($urandom_range(16, 5));
    if (pick < 97) return COUNT_W'($urandom_range(64, 17));
    if (pick < 99) return COUNT_W'($urandom_range(127, 65));
    return '0;
  endfunction

  task automatic add_random_requests(input int n);
    int pick;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 10)      add_request(FN_RESEED, pick_bound(), pick_bound(), pick_count(),
                                      $urandom_range(1));
      else if (pick < 30) add_request(FN_RAW, pick_bound(), pick_bound(), pick_count(),
                                      $urandom_range(1));
      else if (pick < 95) add_request(FN_RANGE, pick_bound(), pick_bound(), pick_count(),
                                      $urandom_range(1));
      else                add_request(FN_UNUSED, pick_bound(), pick_bound(), pick_count(),
                                      $urandom_range(1));
    end
  endtask

  task automatic write_seed(input logic [VAL_W-1:0] s);
    cfg_wdata <= s;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // drain all results, then let a request with no result finish
  task automatic wait_idle();
    while (request_queue.size() != 0 || accepted_cnt != sent_cnt ||
           awaited_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    in_ch.valid      = 1'b0;
    in_ch.func       = FN_RESEED;
    in_ch.low_bound  = '0;
    in_ch.high_bound = '0;
    in_ch.draw_count = '0;
    in_ch.sum_mode   = 1'b0;
    out_ch.ready     = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    rst_n            = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    repeat (SETTLE_CYCLES) @(negedge clk);

    write_seed(32'hffff_ffff);
    in_idle_pct  = 7;
    out_idle_pct = 46;
    add_request(FN_RAW,    0, 0, 1, 1'b0);
    add_request(FN_RESEED, 0, 0, 1, 1'b0);
    add_request(FN_RAW,    INT_MIN, INT_MAX, 127, 1'b1);
    add_request(FN_RANGE,  INT_MIN, INT_MAX, 3, 1'b0);
    add_request(FN_RANGE,  100, -100, 4, 1'b0);
    add_request(FN_RANGE,  5, 5, 2, 1'b0);
    add_request(FN_RANGE,  INT_MIN, INT_MIN, 1, 1'b0);
    add_request(FN_RANGE,  INT_MAX, INT_MAX, 1, 1'b0);
    add_request(FN_RANGE,  INT_MAX, INT_MAX, 5, 1'b1);
    add_request(FN_RANGE,  INT_MIN, INT_MAX, 64, 1'b1);
    add_request(FN_RANGE,  -7, 9, 0, 1'b0);
    add_request(FN_RANGE,  -7, 9, 0, 1'b1);
    add_request(FN_RANGE,  -1000, 1000, 65, 1'b0);
    add_request(FN_RANGE,  INT_MIN, -1, 127, 1'b1);
    add_request(FN_UNUSED, INT_MIN, INT_MAX, 127, 1'b1);
    add_request(FN_RANGE,  0, 1, 64, 1'b0);
    add_request(FN_RESEED, INT_MAX, INT_MIN, 127, 1'b1);
    add_request(FN_RAW,    0, 0, 1, 1'b0);
    add_request(FN_RANGE,  -1, 0, 2, 1'b0);
    add_request(FN_RANGE,  INT_MAX, INT_MIN, 2, 1'b1);
    add_random_requests(RANDOM_PER_PHASE);
    wait_idle();

    write_seed('0);
    in_idle_pct  = 46;
    out_idle_pct = 7;
    add_request(FN_RESEED, 0, 0, 1, 1'b0);
    add_random_requests(RANDOM_PER_PHASE);
    wait_idle();

    write_seed($urandom());
    in_idle_pct  = 0;
    out_idle_pct = 0;
    add_request(FN_RESEED, 0, 0, 1, 1'b0);
    add_random_requests(RANDOM_PER_PHASE);
    wait_idle();

    if (error_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #50_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> filelist.f
hdl/xrrg_pkg.sv
hdl/xrrg_if.sv
hdl/xrrg_mul.sv
hdl/xrrg_mod.sv
hdl/xoshiro_range_random_generator.sv
hdl/xrrg_checker.sv
test/testbench.sv
